[src/sab_pkg.sv]
// ----------------------------------------------------------------------------
// sab_pkg
// Shared types and constants of the suffix array and common prefix builder.
// ----------------------------------------------------------------------------
package sab_pkg;

	// default sizes of the stores
	localparam int MAX_LEN_DEF      = 16384;
	localparam int MAX_ALPHABET_DEF = 256;

	// field widths fixed by the port list
	localparam int IDX_W   = 15;
	localparam int SYM_W   = 8;
	localparam int CFG_W   = 9;
	localparam logic [CFG_W-1:0] ALPHA_RESET = 9'd256;

	// command queue between front and back
	localparam int CMD_DEPTH = 4;
	localparam int CMD_PW    = $clog2(CMD_DEPTH);

	typedef enum logic [1:0] {
		OP_LOAD,
		OP_LOAD_LAST,
		OP_QUERY
	} op_t;

	typedef struct packed {
		op_t              op;
		logic [SYM_W-1:0] symbol;
		logic [IDX_W-1:0] rank;
	} cmd_t;

	typedef struct packed {
		logic [IDX_W-1:0] suffix_start;
		logic [IDX_W-1:0] common_prefix;
		logic             table_ready;
	} res_t;

endpackage

[src/sab_front.sv]
// ----------------------------------------------------------------------------
// sab_front
// Takes input items, classifies them into commands, queues them for the
// back end, and holds the alphabet size register.
// ----------------------------------------------------------------------------
module sab_front (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      push,
	output logic                      full,
	input  logic                      kind,
	input  logic [sab_pkg::SYM_W-1:0] symbol,
	input  logic                      last,
	input  logic [sab_pkg::IDX_W-1:0] rank_index,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [sab_pkg::CFG_W-1:0] cfg_data,
	output logic [sab_pkg::CFG_W-1:0] alpha,
	output logic                      cmd_valid,
	output sab_pkg::cmd_t             cmd,
	input  logic                      cmd_pop
);
	import sab_pkg::*;

	cmd_t              fifo_q [CMD_DEPTH];
	logic [CMD_PW-1:0] wr_ptr_q;
	logic [CMD_PW-1:0] rd_ptr_q;
	logic [CMD_PW:0]   cnt_q;
	logic [CFG_W-1:0]  alpha_q;
	cmd_t              cmd_in;
	logic              do_push;
	logic              do_pop;

	// classify the incoming item
	always_comb begin
		cmd_in.symbol = symbol;
		cmd_in.rank   = rank_index;
		if (kind) begin
			cmd_in.op = OP_QUERY;
		end else if (last) begin
			cmd_in.op = OP_LOAD_LAST;
		end else begin
			cmd_in.op = OP_LOAD;
		end
	end

	assign full      = (cnt_q == (CMD_PW+1)'(CMD_DEPTH));
	assign cmd_valid = (cnt_q != '0);
	assign cmd       = fifo_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = cmd_pop && cmd_valid;
	assign cfg_ready = 1'b1;
	assign alpha     = alpha_q;

	// advance queue pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	// hold queued commands
	always_ff @(posedge clk) begin
		if (do_push) begin
			fifo_q[wr_ptr_q] <= cmd_in;
		end
	end

	// hold the alphabet size
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q <= ALPHA_RESET;
		end else if (cfg_valid) begin
			alpha_q <= cfg_data;
		end
	end

endmodule

[src/sab_back.sv]
// ----------------------------------------------------------------------------
// sab_back
// Carries out commands: stores symbols, runs the prefix doubling sort and
// the common prefix pass over one-read one-write memories, and answers queries.
// ----------------------------------------------------------------------------
module sab_back #(
	parameter int MAX_LEN      = sab_pkg::MAX_LEN_DEF,
	parameter int MAX_ALPHABET = sab_pkg::MAX_ALPHABET_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cmd_valid,
	input  sab_pkg::cmd_t             cmd,
	output logic                      cmd_pop,
	input  logic [sab_pkg::CFG_W-1:0] alpha,
	output logic                      res_valid,
	output sab_pkg::res_t             res,
	input  logic                      res_pop
);
	import sab_pkg::*;

	localparam int SLOTS = MAX_LEN + 1;
	localparam int BK    = MAX_LEN + 1 + MAX_ALPHABET;
	localparam int AW    = $clog2(SLOTS);
	localparam int BW    = $clog2(BK);
	localparam int CW    = $clog2(MAX_LEN + 2);
	localparam int VW    = $clog2(2 * MAX_LEN + MAX_ALPHABET + 4);

	typedef enum logic [5:0] {
		ST_IDLE, ST_Q_WAIT,
		ST_CLAMP_RD, ST_CLAMP_WR,
		ST_SORT_CLR, ST_CNT_Y, ST_CNT_X, ST_CNT_C, ST_CNT_W,
		ST_PS_RD, ST_PS_WR,
		ST_PL_Y, ST_PL_X, ST_PL_C, ST_PL_W,
		ST_DBL_START, ST_GEN_TAIL, ST_GEN_RD, ST_GEN_WR,
		ST_COPY_RD, ST_COPY_WR,
		ST_RR_SA, ST_RR_YB, ST_RR_YBK, ST_RR_WR, ST_RR_END,
		ST_RANK_RD, ST_RANK_WR,
		ST_LCP_INIT, ST_LCP_R, ST_LCP_J, ST_LCP_JC, ST_LCP_TEST,
		ST_LCP_SB, ST_LCP_CMP, ST_LCP_W,
		ST_DONE
	} state_t;

	// memories
	logic [SYM_W-1:0] sym_mem [SLOTS];
	logic [AW-1:0]    sa_mem  [SLOTS];
	logic [VW-1:0]    x_mem   [SLOTS];
	logic [VW-1:0]    y_mem   [SLOTS];
	logic [AW-1:0]    lcp_mem [SLOTS];
	logic [CW-1:0]    cnt_mem [BK];

	logic [AW-1:0]    sym_ra, sym_wa, sa_ra, sa_wa, x_ra, x_wa, y_ra, y_wa, lcp_ra, lcp_wa;
	logic [BW-1:0]    cnt_ra, cnt_wa;
	logic             sym_we, sa_we, x_we, y_we, lcp_we, cnt_we;
	logic [SYM_W-1:0] sym_wd, sym_rd;
	logic [AW-1:0]    sa_wd, sa_rd, lcp_wd, lcp_rd;
	logic [VW-1:0]    x_wd, x_rd, y_wd, y_rd;
	logic [CW-1:0]    cnt_wd, cnt_rd;

	// control and working registers
	state_t        state_q;
	logic [VW-1:0] i_q, p_q, k_q, m_q, n_q, acc_q, h_q, r_q, j_q, b_q, pos_q, key_q;
	logic [VW-1:0] count_q;
	logic [VW-1:0] ya_q, yak_q, yb_q;
	logic [SYM_W-1:0] symq_q;
	logic          aok_q, bok_q, dbl_q, built_q;
	logic          res_valid_q;
	res_t          res_q;

	// derived values
	logic [VW-1:0]    eff_m, alpha_v, sym_v, clamp_v, ld_base, ld_next;
	logic [VW-1:0]    cnt_rd_v, sa_rd_v, ps_sum, cnt_dec, cnt_inc, i_p1, i_m1, n_m1;
	logic [VW-1:0]    bk_sum, ih_sum, jh_sum, sa_mk, p_m1, r_m1, rr_val;
	logic [31:0]      rank_w, sa_w, lcp_w;
	logic             ld_ok, q_hit, rr_same, lcp_go;

	assign alpha_v  = VW'(alpha);
	assign eff_m    = (alpha_v < VW'(2)) ? VW'(2) :
	                  (alpha_v > VW'(MAX_ALPHABET)) ? VW'(MAX_ALPHABET) : alpha_v;
	assign sym_v    = VW'(sym_rd);
	assign clamp_v  = (sym_v < VW'(1)) ? VW'(1) :
	                  (sym_v > m_q - VW'(1)) ? m_q - VW'(1) : sym_v;
	assign ld_base  = built_q ? '0 : count_q;
	assign ld_ok    = ld_base < VW'(MAX_LEN);
	assign ld_next  = ld_ok ? ld_base + VW'(1) : ld_base;
	assign rank_w   = 32'(cmd.rank);
	assign q_hit    = built_q && (rank_w <= 32'(count_q));
	assign cnt_rd_v = VW'(cnt_rd);
	assign sa_rd_v  = VW'(sa_rd);
	assign ps_sum   = acc_q + cnt_rd_v;
	assign cnt_dec  = cnt_rd_v - VW'(1);
	assign cnt_inc  = cnt_rd_v + VW'(1);
	assign i_p1     = i_q + VW'(1);
	assign i_m1     = i_q - VW'(1);
	assign n_m1     = n_q - VW'(1);
	assign bk_sum   = b_q + k_q;
	assign ih_sum   = i_q + h_q;
	assign jh_sum   = j_q + h_q;
	assign sa_mk    = sa_rd_v - k_q;
	assign p_m1     = p_q - VW'(1);
	assign r_m1     = x_rd - VW'(1);
	assign rr_same  = (i_q != '0) && (ya_q == yb_q) && aok_q && bok_q && (yak_q == y_rd);
	assign rr_val   = (i_q == '0) ? '0 : (rr_same ? p_m1 : p_q);
	assign lcp_go   = (ih_sum < n_q) && (jh_sum < n_q);
	assign sa_w     = 32'(sa_rd);
	assign lcp_w    = 32'(lcp_rd);

	assign cmd_pop   = (state_q == ST_IDLE) && cmd_valid &&
	                   ((cmd.op != OP_QUERY) || !res_valid_q);
	assign res_valid = res_valid_q;
	assign res       = res_q;

	// drive memory ports from the current step
	always_comb begin
		sym_ra = '0; sym_we = 1'b0; sym_wa = '0; sym_wd = '0;
		sa_ra  = '0; sa_we  = 1'b0; sa_wa  = '0; sa_wd  = '0;
		x_ra   = '0; x_we   = 1'b0; x_wa   = '0; x_wd   = '0;
		y_ra   = '0; y_we   = 1'b0; y_wa   = '0; y_wd   = '0;
		lcp_ra = '0; lcp_we = 1'b0; lcp_wa = '0; lcp_wd = '0;
		cnt_ra = '0; cnt_we = 1'b0; cnt_wa = '0; cnt_wd = '0;
		case (state_q)
			ST_IDLE: begin
				if (cmd_valid && (cmd.op != OP_QUERY) && ld_ok) begin
					sym_we = 1'b1;
					sym_wa = ld_base[AW-1:0];
					sym_wd = cmd.symbol;
				end
				sa_ra  = rank_w[AW-1:0];
				lcp_ra = rank_w[AW-1:0];
			end
			ST_CLAMP_RD: begin
				if (i_q == n_m1) begin
					sym_we = 1'b1; sym_wa = i_q[AW-1:0]; sym_wd = '0;
					x_we   = 1'b1; x_wa   = i_q[AW-1:0]; x_wd   = '0;
					y_we   = 1'b1; y_wa   = i_q[AW-1:0]; y_wd   = i_q;
				end else begin
					sym_ra = i_q[AW-1:0];
				end
			end
			ST_CLAMP_WR: begin
				sym_we = 1'b1; sym_wa = i_q[AW-1:0]; sym_wd = clamp_v[SYM_W-1:0];
				x_we   = 1'b1; x_wa   = i_q[AW-1:0]; x_wd   = clamp_v;
				y_we   = 1'b1; y_wa   = i_q[AW-1:0]; y_wd   = i_q;
			end
			ST_SORT_CLR: begin
				cnt_we = 1'b1; cnt_wa = i_q[BW-1:0]; cnt_wd = '0;
			end
			ST_CNT_Y: y_ra = i_q[AW-1:0];
			ST_CNT_X: x_ra = y_rd[AW-1:0];
			ST_CNT_C: cnt_ra = x_rd[BW-1:0];
			ST_CNT_W: begin
				cnt_we = 1'b1; cnt_wa = key_q[BW-1:0]; cnt_wd = cnt_inc[CW-1:0];
			end
			ST_PS_RD: cnt_ra = i_q[BW-1:0];
			ST_PS_WR: begin
				cnt_we = 1'b1; cnt_wa = i_q[BW-1:0]; cnt_wd = ps_sum[CW-1:0];
			end
			ST_PL_Y: y_ra = i_m1[AW-1:0];
			ST_PL_X: x_ra = y_rd[AW-1:0];
			ST_PL_C: cnt_ra = x_rd[BW-1:0];
			ST_PL_W: begin
				cnt_we = 1'b1; cnt_wa = key_q[BW-1:0]; cnt_wd = cnt_dec[CW-1:0];
				sa_we  = 1'b1; sa_wa  = cnt_dec[AW-1:0]; sa_wd  = pos_q[AW-1:0];
			end
			ST_GEN_TAIL: begin
				y_we = 1'b1; y_wa = p_q[AW-1:0]; y_wd = i_q;
			end
			ST_GEN_RD: sa_ra = i_q[AW-1:0];
			ST_GEN_WR: begin
				if (sa_rd_v >= k_q) begin
					y_we = 1'b1; y_wa = p_q[AW-1:0]; y_wd = sa_mk;
				end
			end
			ST_COPY_RD: x_ra = i_q[AW-1:0];
			ST_COPY_WR: begin
				y_we = 1'b1; y_wa = i_q[AW-1:0]; y_wd = x_rd;
			end
			ST_RR_SA: sa_ra = i_q[AW-1:0];
			ST_RR_YB: y_ra = sa_rd;
			ST_RR_YBK: y_ra = (bk_sum < n_q) ? bk_sum[AW-1:0] : '0;
			ST_RR_WR: begin
				x_we = 1'b1; x_wa = b_q[AW-1:0]; x_wd = rr_val;
			end
			ST_RANK_RD: sa_ra = i_q[AW-1:0];
			ST_RANK_WR: begin
				x_we = 1'b1; x_wa = sa_rd; x_wd = i_q;
			end
			ST_LCP_INIT: begin
				lcp_we = 1'b1; lcp_wa = '0; lcp_wd = '0;
			end
			ST_LCP_R: x_ra = i_q[AW-1:0];
			ST_LCP_J: sa_ra = r_m1[AW-1:0];
			ST_LCP_TEST: sym_ra = ih_sum[AW-1:0];
			ST_LCP_SB: sym_ra = jh_sum[AW-1:0];
			ST_LCP_W: begin
				lcp_we = 1'b1; lcp_wa = r_q[AW-1:0]; lcp_wd = h_q[AW-1:0];
			end
			default: begin
			end
		endcase
	end

	// memories with registered read data
	always_ff @(posedge clk) begin
		if (sym_we) sym_mem[sym_wa] <= sym_wd;
		sym_rd <= sym_mem[sym_ra];
	end
	always_ff @(posedge clk) begin
		if (sa_we) sa_mem[sa_wa] <= sa_wd;
		sa_rd <= sa_mem[sa_ra];
	end
	always_ff @(posedge clk) begin
		if (x_we) x_mem[x_wa] <= x_wd;
		x_rd <= x_mem[x_ra];
	end
	always_ff @(posedge clk) begin
		if (y_we) y_mem[y_wa] <= y_wd;
		y_rd <= y_mem[y_ra];
	end
	always_ff @(posedge clk) begin
		if (lcp_we) lcp_mem[lcp_wa] <= lcp_wd;
		lcp_rd <= lcp_mem[lcp_ra];
	end
	always_ff @(posedge clk) begin
		if (cnt_we) cnt_mem[cnt_wa] <= cnt_wd;
		cnt_rd <= cnt_mem[cnt_ra];
	end

	// sequence the build and the queries
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			i_q <= '0; p_q <= '0; k_q <= '0; m_q <= '0; n_q <= '0; acc_q <= '0;
			h_q <= '0; r_q <= '0; j_q <= '0; b_q <= '0; pos_q <= '0; key_q <= '0;
			count_q <= '0; ya_q <= '0; yak_q <= '0; yb_q <= '0; symq_q <= '0;
			aok_q <= 1'b0; bok_q <= 1'b0; dbl_q <= 1'b0; built_q <= 1'b0;
			res_valid_q <= 1'b0; res_q <= '0;
		end else begin
			// drop the result once transferred
			if (res_pop && res_valid_q) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (cmd_pop) begin
						if (cmd.op == OP_QUERY) begin
							if (q_hit) begin
								state_q <= ST_Q_WAIT;
							end else begin
								res_q       <= '0;
								res_valid_q <= 1'b1;
							end
						end else begin
							built_q <= 1'b0;
							count_q <= ld_next;
							if (cmd.op == OP_LOAD_LAST) begin
								n_q     <= ld_next + VW'(1);
								m_q     <= eff_m;
								i_q     <= '0;
								state_q <= ST_CLAMP_RD;
							end
						end
					end
				end
				ST_Q_WAIT: begin
					res_q.suffix_start  <= sa_w[IDX_W-1:0];
					res_q.common_prefix <= lcp_w[IDX_W-1:0];
					res_q.table_ready   <= 1'b1;
					res_valid_q         <= 1'b1;
					state_q             <= ST_IDLE;
				end
				ST_CLAMP_RD: begin
					if (i_q == n_m1) begin
						i_q     <= '0;
						dbl_q   <= 1'b0;
						state_q <= ST_SORT_CLR;
					end else begin
						state_q <= ST_CLAMP_WR;
					end
				end
				ST_CLAMP_WR: begin
					i_q     <= i_p1;
					state_q <= ST_CLAMP_RD;
				end
				// counting sort: clear, count, prefix sum, place
				ST_SORT_CLR: begin
					if (i_q == m_q - VW'(1)) begin
						i_q     <= '0;
						state_q <= ST_CNT_Y;
					end else begin
						i_q <= i_p1;
					end
				end
				ST_CNT_Y: state_q <= ST_CNT_X;
				ST_CNT_X: state_q <= ST_CNT_C;
				ST_CNT_C: begin
					key_q   <= x_rd;
					state_q <= ST_CNT_W;
				end
				ST_CNT_W: begin
					if (i_p1 == n_q) begin
						i_q     <= '0;
						acc_q   <= '0;
						state_q <= ST_PS_RD;
					end else begin
						i_q     <= i_p1;
						state_q <= ST_CNT_Y;
					end
				end
				ST_PS_RD: state_q <= ST_PS_WR;
				ST_PS_WR: begin
					acc_q <= ps_sum;
					if (i_p1 == m_q) begin
						i_q     <= n_q;
						state_q <= ST_PL_Y;
					end else begin
						i_q     <= i_p1;
						state_q <= ST_PS_RD;
					end
				end
				ST_PL_Y: state_q <= ST_PL_X;
				ST_PL_X: begin
					pos_q   <= y_rd;
					state_q <= ST_PL_C;
				end
				ST_PL_C: begin
					key_q   <= x_rd;
					state_q <= ST_PL_W;
				end
				ST_PL_W: begin
					if (i_q == VW'(1)) begin
						if (dbl_q) begin
							i_q     <= '0;
							state_q <= ST_COPY_RD;
						end else begin
							k_q     <= VW'(1);
							state_q <= ST_DBL_START;
						end
					end else begin
						i_q     <= i_m1;
						state_q <= ST_PL_Y;
					end
				end
				// doubling round: second key order
				ST_DBL_START: begin
					if (k_q > n_q) begin
						i_q     <= '0;
						state_q <= ST_RANK_RD;
					end else begin
						p_q     <= '0;
						i_q     <= n_q - k_q;
						state_q <= ST_GEN_TAIL;
					end
				end
				ST_GEN_TAIL: begin
					p_q <= p_q + VW'(1);
					if (i_q == n_m1) begin
						i_q     <= '0;
						state_q <= ST_GEN_RD;
					end else begin
						i_q <= i_p1;
					end
				end
				ST_GEN_RD: state_q <= ST_GEN_WR;
				ST_GEN_WR: begin
					if (sa_rd_v >= k_q) begin
						p_q <= p_q + VW'(1);
					end
					if (i_p1 == n_q) begin
						i_q     <= '0;
						dbl_q   <= 1'b1;
						state_q <= ST_SORT_CLR;
					end else begin
						i_q     <= i_p1;
						state_q <= ST_GEN_RD;
					end
				end
				// keep old ranks as the compare key
				ST_COPY_RD: state_q <= ST_COPY_WR;
				ST_COPY_WR: begin
					if (i_p1 == n_q) begin
						i_q     <= '0;
						p_q     <= VW'(1);
						state_q <= ST_RR_SA;
					end else begin
						i_q     <= i_p1;
						state_q <= ST_COPY_RD;
					end
				end
				// assign new ranks along sorted order
				ST_RR_SA: state_q <= ST_RR_YB;
				ST_RR_YB: begin
					b_q     <= sa_rd_v;
					state_q <= ST_RR_YBK;
				end
				ST_RR_YBK: begin
					yb_q    <= y_rd;
					bok_q   <= bk_sum < n_q;
					state_q <= ST_RR_WR;
				end
				ST_RR_WR: begin
					if ((i_q != '0) && !rr_same) begin
						p_q <= p_q + VW'(1);
					end
					ya_q  <= yb_q;
					yak_q <= y_rd;
					aok_q <= bok_q;
					if (i_p1 == n_q) begin
						state_q <= ST_RR_END;
					end else begin
						i_q     <= i_p1;
						state_q <= ST_RR_SA;
					end
				end
				ST_RR_END: begin
					if (p_q >= n_q) begin
						i_q     <= '0;
						state_q <= ST_RANK_RD;
					end else begin
						m_q     <= p_q;
						k_q     <= k_q << 1;
						state_q <= ST_DBL_START;
					end
				end
				// inverse of the suffix order
				ST_RANK_RD: state_q <= ST_RANK_WR;
				ST_RANK_WR: begin
					if (i_p1 == n_q) begin
						state_q <= ST_LCP_INIT;
					end else begin
						i_q     <= i_p1;
						state_q <= ST_RANK_RD;
					end
				end
				// common prefix pass in text order
				ST_LCP_INIT: begin
					i_q     <= '0;
					h_q     <= '0;
					state_q <= ST_LCP_R;
				end
				ST_LCP_R: state_q <= ST_LCP_J;
				ST_LCP_J: begin
					r_q <= x_rd;
					if (x_rd == '0) begin
						h_q <= '0;
						if (i_p1 == n_m1) begin
							state_q <= ST_DONE;
						end else begin
							i_q     <= i_p1;
							state_q <= ST_LCP_R;
						end
					end else begin
						h_q     <= (h_q != '0) ? h_q - VW'(1) : '0;
						state_q <= ST_LCP_JC;
					end
				end
				ST_LCP_JC: begin
					j_q     <= sa_rd_v;
					state_q <= ST_LCP_TEST;
				end
				ST_LCP_TEST: begin
					state_q <= lcp_go ? ST_LCP_SB : ST_LCP_W;
				end
				ST_LCP_SB: begin
					symq_q  <= sym_rd;
					state_q <= ST_LCP_CMP;
				end
				ST_LCP_CMP: begin
					if (sym_rd == symq_q) begin
						h_q     <= h_q + VW'(1);
						state_q <= ST_LCP_TEST;
					end else begin
						state_q <= ST_LCP_W;
					end
				end
				ST_LCP_W: begin
					if (i_p1 == n_m1) begin
						state_q <= ST_DONE;
					end else begin
						i_q     <= i_p1;
						state_q <= ST_LCP_R;
					end
				end
				ST_DONE: begin
					built_q <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

[src/suffix_array_lcp_builder.sv]
// ----------------------------------------------------------------------------
// suffix_array_lcp_builder
// Loads a string, builds its suffix array by prefix doubling and the
// adjacent common prefix array, and answers rank queries.
// ----------------------------------------------------------------------------
// Loads: one per cycle while the four-entry command queue is not full; the idle back
// end takes each without waiting on the last. Queries: a hit passes a wait state for
// the table read, a miss skips it; no new query is taken while a result waits. A
// last-marked load starts a build: a counting sort, doubling rounds (second key order,
// sort, rank copy, re-rank), the inverse order and the common prefix pass. Reset
// clears the queue, load count, built flag; alphabet 256.
module suffix_array_lcp_builder #(
	parameter int MAX_LEN      = sab_pkg::MAX_LEN_DEF,
	parameter int MAX_ALPHABET = sab_pkg::MAX_ALPHABET_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      push,
	output logic                      full,
	input  logic                      kind,
	input  logic [sab_pkg::SYM_W-1:0] symbol,
	input  logic                      last,
	input  logic [sab_pkg::IDX_W-1:0] rank_index,
	output logic                      empty,
	input  logic                      pop,
	output logic [sab_pkg::IDX_W-1:0] suffix_start,
	output logic [sab_pkg::IDX_W-1:0] common_prefix,
	output logic                      table_ready,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [sab_pkg::CFG_W-1:0] cfg_data
);
	import sab_pkg::*;

	logic             cmd_valid;
	logic             cmd_pop;
	cmd_t             cmd;
	logic [CFG_W-1:0] alpha;
	logic             res_valid;
	res_t             res;

	sab_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.kind       (kind),
		.symbol     (symbol),
		.last       (last),
		.rank_index (rank_index),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.alpha      (alpha),
		.cmd_valid  (cmd_valid),
		.cmd        (cmd),
		.cmd_pop    (cmd_pop)
	);

	sab_back #(
		.MAX_LEN      (MAX_LEN),
		.MAX_ALPHABET (MAX_ALPHABET)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.alpha     (alpha),
		.res_valid (res_valid),
		.res       (res),
		.res_pop   (pop)
	);

	// present the waiting result
	assign empty         = !res_valid;
	assign suffix_start  = res.suffix_start;
	assign common_prefix = res.common_prefix;
	assign table_ready   = res.table_ready;

endmodule

[dv/suffix_array_lcp_builder_tb.sv]
// ----------------------------------------------------------------------------
// suffix_array_lcp_builder_tb
// Self-checking bench for the suffix array and common prefix builder. Loads
// strings through the input queue, queries ranks, and compares every result
// against a local prefix-doubling and Kasai model, under varied alphabet sizes
// and under sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module suffix_array_lcp_builder_tb;
	import sab_pkg::*;

	localparam int LEN_MAX   = MAX_LEN_DEF;
	localparam int ALPHA_MAX = MAX_ALPHABET_DEF;
	localparam logic KIND_LOAD  = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	logic             clk;
	logic             arst_n;
	logic             push;
	logic             full;
	logic             kind;
	logic [SYM_W-1:0] symbol;
	logic             last;
	logic [IDX_W-1:0] rank_index;
	logic             empty;
	logic             pop;
	logic [IDX_W-1:0] suffix_start;
	logic [IDX_W-1:0] common_prefix;
	logic             table_ready;
	logic             cfg_valid;
	logic             cfg_ready;
	logic [CFG_W-1:0] cfg_data;

	suffix_array_lcp_builder u_top (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .kind(kind),
		.symbol(symbol), .last(last), .rank_index(rank_index), .empty(empty),
		.pop(pop), .suffix_start(suffix_start), .common_prefix(common_prefix),
		.table_ready(table_ready), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	// model state
	int unsigned str_mem [0:LEN_MAX];
	int unsigned sorted_pos [0:LEN_MAX];
	int unsigned pos_rank [0:LEN_MAX];
	int unsigned aux_key [0:LEN_MAX];
	int unsigned lcp_mem [0:LEN_MAX];
	int unsigned bucket [0:LEN_MAX+ALPHA_MAX];
	int unsigned str_len;
	bit          tables_built;
	int unsigned alpha_reg;

	res_t answers_due [$];
	int   mismatches;
	int   items_sent;
	int   send_idle_pct;
	int   pop_stall_pct;
	int   hold_cycles;

	// clock and time limit
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#40_000_000;
		$display("suffix_array_lcp_builder_tb failed");
		$finish;
	end

	task automatic report_mismatch(input string msg);
		$display("MISMATCH @%0t: %s", $realtime, msg);
		mismatches++;
	endtask

	// counting sort of aux_key order by pos_rank keys
	function automatic void bucket_sort(input int unsigned n, input int unsigned m);
		int unsigned i;
		int unsigned p;
		for (i = 0; i < LEN_MAX + ALPHA_MAX + 1; i++) bucket[i] = 0;
		for (i = 0; i < n; i++) bucket[pos_rank[aux_key[i]]]++;
		for (i = 1; i < m; i++) bucket[i] += bucket[i-1];
		for (i = n; i > 0; i--) begin
			p = aux_key[i-1];
			bucket[pos_rank[p]]--;
			sorted_pos[bucket[pos_rank[p]]] = p;
		end
	endfunction

	function automatic void build_suffix_tables();
		int unsigned n;
		int unsigned m;
		int unsigned i;
		int unsigned k;
		int unsigned h;
		int unsigned p;
		int unsigned a;
		int unsigned b;
		int unsigned r;
		int unsigned j;
		int unsigned t;
		bit same;
		n = str_len + 1;
		m = alpha_reg;
		if (m < 2) m = 2;
		if (m > ALPHA_MAX) m = ALPHA_MAX;
		// clamp symbols into the alphabet, then append the sentinel
		for (i = 0; i < str_len; i++) begin
			if (str_mem[i] < 1) str_mem[i] = 1;
			if (str_mem[i] > m - 1) str_mem[i] = m - 1;
		end
		str_mem[str_len] = 0;
		for (i = 0; i < n; i++) begin
			pos_rank[i] = str_mem[i];
			aux_key[i] = i;
		end
		bucket_sort(n, m);
		for (k = 1; k <= n; k <<= 1) begin
			p = 0;
			for (i = n - k; i < n; i++) aux_key[p++] = i;
			for (i = 0; i < n; i++)
				if (sorted_pos[i] >= k) aux_key[p++] = sorted_pos[i] - k;
			bucket_sort(n, m);
			// swap rank and key arrays
			for (i = 0; i < n; i++) begin
				t = pos_rank[i];
				pos_rank[i] = aux_key[i];
				aux_key[i] = t;
			end
			p = 1;
			pos_rank[sorted_pos[0]] = 0;
			for (i = 1; i < n; i++) begin
				a = sorted_pos[i-1];
				b = sorted_pos[i];
				same = aux_key[a] == aux_key[b] && a + k < n && b + k < n &&
				       aux_key[a+k] == aux_key[b+k];
				if (same) pos_rank[b] = p - 1;
				else pos_rank[b] = p++;
			end
			if (p >= n) break;
			m = p;
		end
		for (i = 0; i < n; i++) pos_rank[sorted_pos[i]] = i;
		// adjacent common prefixes
		lcp_mem[0] = 0;
		h = 0;
		for (i = 0; i < str_len; i++) begin
			r = pos_rank[i];
			if (h != 0) h--;
			if (r == 0) begin
				h = 0;
				continue;
			end
			j = sorted_pos[r-1];
			while (i + h < n && j + h < n && str_mem[i+h] == str_mem[j+h]) h++;
			lcp_mem[r] = h;
		end
		tables_built = 1'b1;
	endfunction

	function automatic void predict_item(input logic k, input logic [SYM_W-1:0] s,
		input logic l, input logic [IDX_W-1:0] ri);
		res_t ans;
		if (k == KIND_LOAD) begin
			if (tables_built) begin
				tables_built = 1'b0;
				str_len = 0;
			end
			if (str_len < LEN_MAX) str_mem[str_len++] = 32'(s);
			if (l) build_suffix_tables();
		end else begin
			if (tables_built && ri <= str_len) begin
				ans.suffix_start  = IDX_W'(sorted_pos[ri]);
				ans.common_prefix = IDX_W'(lcp_mem[ri]);
				ans.table_ready   = 1'b1;
			end else begin
				ans = '0;
			end
			answers_due.push_back(ans);
		end
	endfunction

	// check each result transfer against the oldest answer due
	always @(posedge clk) begin
		res_t exp_r;
		if (arst_n && pop && !empty) begin
			if (answers_due.size() == 0) begin
				report_mismatch("result with no query outstanding");
			end else begin
				exp_r = answers_due.pop_front();
				if (suffix_start !== exp_r.suffix_start)
					report_mismatch($sformatf("suffix_start %0d, want %0d",
						suffix_start, exp_r.suffix_start));
				if (common_prefix !== exp_r.common_prefix)
					report_mismatch($sformatf("common_prefix %0d, want %0d",
						common_prefix, exp_r.common_prefix));
				if (table_ready !== exp_r.table_ready)
					report_mismatch($sformatf("table_ready %0b, want %0b",
						table_ready, exp_r.table_ready));
			end
		end
	end

	// receiver: long hold-off first, else random stalls
	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			pop <= 1'b0;
			hold_cycles <= hold_cycles - 1;
		end else begin
			pop <= ($urandom_range(99) >= pop_stall_pct);
		end
	end

	// offer one item; returns at the falling edge after its transfer
	task automatic send_item(input logic k, input logic [SYM_W-1:0] s, input logic l,
		input logic [IDX_W-1:0] ri);
		if ($urandom_range(99) < send_idle_pct) begin
			push = 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
		kind = k;
		symbol = s;
		last = l;
		rank_index = ri;
		push = 1'b1;
		@(posedge clk);
		while (full) @(posedge clk);
		predict_item(k, s, l, ri);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic wait_results();
		int c;
		c = 0;
		push = 1'b0;
		while (answers_due.size() != 0 && c < 3_000_000) begin
			@(negedge clk);
			c++;
		end
	endtask

	// query once so any build has finished, drain, then let the back end settle
	task automatic settle();
		send_item(KIND_QUERY, 8'd0, 1'b0, '0);
		wait_results();
		repeat (40) @(negedge clk);
	endtask

	task automatic write_alphabet(input logic [CFG_W-1:0] v);
		settle();
		cfg_data = v;
		cfg_valid = 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		alpha_reg = 32'(v);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	function automatic int unsigned alpha_eff();
		if (alpha_reg < 2) return 2;
		if (alpha_reg > ALPHA_MAX) return ALPHA_MAX;
		return alpha_reg;
	endfunction

	// load a string of the given length; wild mixes in out-of-range symbols
	task automatic load_string(input int unsigned len, input bit wild);
		int unsigned i;
		logic [SYM_W-1:0] s;
		for (i = 0; i < len; i++) begin
			if (wild && $urandom_range(3) == 0) s = SYM_W'($urandom);
			else s = SYM_W'($urandom_range(1, alpha_eff() - 1));
			send_item(KIND_LOAD, s, i == len - 1, IDX_W'($urandom));
		end
	endtask

	task automatic query_ranks(input int unsigned cnt, input int unsigned len);
		int unsigned i;
		logic [IDX_W-1:0] ri;
		for (i = 0; i < cnt; i++) begin
			if ($urandom_range(9) == 0) ri = IDX_W'($urandom);
			else ri = IDX_W'($urandom_range(0, len + 1));
			send_item(KIND_QUERY, SYM_W'($urandom), 1'($urandom_range(1)), ri);
		end
	endtask

	task automatic test_before_build();
		send_item(KIND_QUERY, 8'hff, 1'b1, '0);
		send_item(KIND_QUERY, 8'h00, 1'b0, 15'h7fff);
		wait_results();
	endtask

	task automatic test_directed();
		int unsigned i;
		// smallest alphabet: every symbol clamps to one
		write_alphabet(9'd2);
		send_item(KIND_LOAD, 8'd0, 1'b0, '0);
		send_item(KIND_LOAD, 8'hff, 1'b0, '0);
		send_item(KIND_LOAD, 8'd1, 1'b1, '0);
		for (i = 0; i < 5; i++) send_item(KIND_QUERY, 8'd0, 1'b0, IDX_W'(i));
		// alphabet above range, single symbol string, extreme symbols
		write_alphabet(9'h1ff);
		send_item(KIND_LOAD, 8'hff, 1'b1, 15'h7fff);
		send_item(KIND_QUERY, 8'd0, 1'b1, 15'd1);
		send_item(KIND_QUERY, 8'd0, 1'b0, 15'd2);
		send_item(KIND_QUERY, 8'd0, 1'b0, 15'h7fff);
		// repeated symbol, then a load without last clears the tables
		send_item(KIND_LOAD, 8'd7, 1'b0, '0);
		send_item(KIND_LOAD, 8'd7, 1'b0, '0);
		send_item(KIND_LOAD, 8'd7, 1'b1, '0);
		send_item(KIND_QUERY, 8'd0, 1'b0, 15'd3);
		send_item(KIND_LOAD, 8'd0, 1'b0, '0);
		send_item(KIND_QUERY, 8'd0, 1'b0, 15'd0);
		write_alphabet(9'd0);
		load_string(4, 1'b1);
		query_ranks(4, 4);
		write_alphabet(ALPHA_RESET);
	endtask

	// block the receiver so the input side fills and stalls
	task automatic test_fill_stall();
		load_string(12, 1'b0);
		wait_results();
		hold_cycles = 500;
		query_ranks(40, 12);
		wait_results();
	endtask

	task automatic test_large();
		write_alphabet(9'd4);
		load_string(200, 1'b0);
		query_ranks(30, 200);
		write_alphabet(ALPHA_RESET);
		load_string(150, 1'b1);
		query_ranks(20, 150);
		wait_results();
	endtask

	task automatic test_random(input int idle_pct, input int stall_pct, input int quota);
		int goal;
		int unsigned len;
		int sel;
		send_idle_pct = idle_pct;
		pop_stall_pct = stall_pct;
		goal = items_sent + quota;
		while (items_sent < goal) begin
			sel = $urandom_range(99);
			if (sel < 8) begin
				// new alphabet setting
				case ($urandom_range(3))
					0: write_alphabet(CFG_W'($urandom_range(2, 5)));
					1: write_alphabet(ALPHA_RESET);
					2: write_alphabet(CFG_W'($urandom));
					default: write_alphabet(CFG_W'($urandom_range(2, 256)));
				endcase
			end else if (sel < 85) begin
				len = ($urandom_range(9) == 0) ? $urandom_range(25, 80) : $urandom_range(1, 20);
				load_string(len, $urandom_range(4) == 0);
				query_ranks($urandom_range(2, 10), len);
			end else if (sel < 93) begin
				// unfinished string: tables cleared, answers empty
				load_string(0, 1'b0);
				send_item(KIND_LOAD, SYM_W'($urandom), 1'b0, IDX_W'($urandom));
				query_ranks($urandom_range(1, 3), 2);
			end else begin
				query_ranks($urandom_range(1, 4), 20);
			end
		end
		wait_results();
	endtask

	initial begin
		arst_n = 1'b0;
		push = 1'b0;
		kind = KIND_LOAD;
		symbol = '0;
		last = 1'b0;
		rank_index = '0;
		pop = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = ALPHA_RESET;
		hold_cycles = 0;
		send_idle_pct = 0;
		pop_stall_pct = 0;
		mismatches = 0;
		items_sent = 0;
		str_len = 0;
		tables_built = 1'b0;
		alpha_reg = 32'(ALPHA_RESET);
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_before_build();
		test_directed();
		test_fill_stall();
		test_random(0, 0, 90);
		test_random(77, 0, 70);
		test_random(0, 77, 70);
		test_random(18, 18, 90);
		send_idle_pct = 0;
		pop_stall_pct = 20;
		test_large();

		wait_results();
		repeat (200) @(negedge clk);
		if (answers_due.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", answers_due.size()));
		if (mismatches == 0) begin
			$display("suffix_array_lcp_builder_tb passed");
		end else begin
			$display("suffix_array_lcp_builder_tb failed");
		end
		$finish;
	end

endmodule

[files.f]
src/sab_pkg.sv
src/sab_front.sv
src/sab_back.sv
src/suffix_array_lcp_builder.sv
dv/suffix_array_lcp_builder_tb.sv
